### hdl/ps2_set2_to_hid_usage_decoder_top_assert.svh
// Assertion macros for the PS/2 set 2 to HID usage decoder checker.
// Used by ps2hid_checker.sv only; no other dependencies.
`ifndef PS2_SET2_TO_HID_USAGE_DECODER_TOP_ASSERT_SVH
`define PS2_SET2_TO_HID_USAGE_DECODER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PS2HID_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PS2HID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ps2hid_pkg.sv
// Shared types, constants and the scan code lookup table of the decoder.
// No dependencies.
package ps2hid_pkg;

  localparam logic [7:0] PfxPause  = 8'he1;
  localparam logic [7:0] PfxExt    = 8'he0;
  localparam logic [7:0] PfxRel    = 8'hf0;
  localparam logic [7:0] FakeShift = 8'h12;
  localparam logic [2:0] PauseTail = 3'd7;

  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [1:0] {
    StNone  = 2'd0,
    StKey   = 2'd1,
    StUnsup = 2'd2
  } status_e;

  typedef enum logic {
    KindNone   = 1'b0,
    KindLookup = 1'b1
  } cmd_kind_e;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    cmd_kind_e  kind;
    logic       ext;
    logic       rel;
    logic [7:0] code;
  } cmd_t;

  function automatic logic [7:0] usage_lookup(logic [7:0] code, logic ext);
    logic [7:0] u;
    u = 8'h00;
    if (ext) begin
      case (code)
        8'h11: u = 8'he6; 8'h14: u = 8'he4; 8'h1f: u = 8'he3; 8'h27: u = 8'he7;
        8'h2f: u = 8'h65; 8'h4a: u = 8'h54; 8'h5a: u = 8'h58; 8'h69: u = 8'h4d;
        8'h6b: u = 8'h50; 8'h6c: u = 8'h4a; 8'h70: u = 8'h49; 8'h71: u = 8'h4c;
        8'h72: u = 8'h51; 8'h74: u = 8'h4f; 8'h75: u = 8'h52; 8'h7a: u = 8'h4e;
        8'h7c: u = 8'h46; 8'h7d: u = 8'h4b;
        default: u = 8'h00;
      endcase
    end else begin
      case (code)
        8'h01: u = 8'h42; 8'h03: u = 8'h3e; 8'h04: u = 8'h3c; 8'h05: u = 8'h3a;
        8'h06: u = 8'h3b; 8'h07: u = 8'h45; 8'h09: u = 8'h43; 8'h0a: u = 8'h41;
        8'h0b: u = 8'h3f; 8'h0c: u = 8'h3d; 8'h0d: u = 8'h2b; 8'h0e: u = 8'h35;
        8'h11: u = 8'he2; 8'h12: u = 8'he1; 8'h14: u = 8'he0; 8'h15: u = 8'h14;
        8'h16: u = 8'h1e; 8'h1a: u = 8'h1d; 8'h1b: u = 8'h16; 8'h1c: u = 8'h04;
        8'h1d: u = 8'h1a; 8'h1e: u = 8'h1f; 8'h21: u = 8'h06; 8'h22: u = 8'h1b;
        8'h23: u = 8'h07; 8'h24: u = 8'h08; 8'h25: u = 8'h21; 8'h26: u = 8'h20;
        8'h29: u = 8'h2c; 8'h2a: u = 8'h19; 8'h2b: u = 8'h09; 8'h2c: u = 8'h17;
        8'h2d: u = 8'h15; 8'h2e: u = 8'h22; 8'h31: u = 8'h11; 8'h32: u = 8'h05;
        8'h33: u = 8'h0b; 8'h34: u = 8'h0a; 8'h35: u = 8'h1c; 8'h36: u = 8'h23;
        8'h3a: u = 8'h10; 8'h3b: u = 8'h0d; 8'h3c: u = 8'h18; 8'h3d: u = 8'h24;
        8'h3e: u = 8'h25; 8'h41: u = 8'h36; 8'h42: u = 8'h0e; 8'h43: u = 8'h0c;
        8'h44: u = 8'h12; 8'h45: u = 8'h27; 8'h46: u = 8'h26; 8'h49: u = 8'h37;
        8'h4a: u = 8'h38; 8'h4b: u = 8'h0f; 8'h4c: u = 8'h33; 8'h4d: u = 8'h13;
        8'h4e: u = 8'h2d; 8'h52: u = 8'h34; 8'h54: u = 8'h2f; 8'h55: u = 8'h2e;
        8'h58: u = 8'h39; 8'h59: u = 8'he5; 8'h5a: u = 8'h28; 8'h5b: u = 8'h30;
        8'h5d: u = 8'h31; 8'h61: u = 8'h64; 8'h66: u = 8'h2a; 8'h69: u = 8'h59;
        8'h6b: u = 8'h5c; 8'h6c: u = 8'h5f; 8'h70: u = 8'h62; 8'h71: u = 8'h63;
        8'h72: u = 8'h5a; 8'h73: u = 8'h5d; 8'h74: u = 8'h5e; 8'h75: u = 8'h60;
        8'h76: u = 8'h29; 8'h77: u = 8'h53; 8'h78: u = 8'h44; 8'h79: u = 8'h57;
        8'h7a: u = 8'h5b; 8'h7b: u = 8'h56; 8'h7c: u = 8'h55; 8'h7d: u = 8'h61;
        8'h7e: u = 8'h47; 8'h83: u = 8'h40;
        default: u = 8'h00;
      endcase
    end
    return u;
  endfunction

endpackage

### hdl/ps2_set2_to_hid_usage_decoder_top.sv
// PS/2 scan code set 2 to HID usage decoder, top level.
// Instantiates ps2hid_front, ps2hid_queue and ps2hid_back; uses ps2hid_pkg.
//
// Usage: feed raw keyboard bytes on scan_byte_i with in_valid_i/in_ready_o.
// Every accepted byte yields exactly one transaction on the output channel
// (out_valid_o/out_ready_i) carrying status_o, usage_o and pressed_o, in
// byte order. Status 0 means no key event (prefix, pause tail, fake shift),
// 1 a key transition, 2 an unsupported code; usage and pressed are zero
// unless status is 1.
// Throughput: one byte per cycle while the receiver takes every result, as
// the front updates its flags and the back looks up the table for each byte.
// When the receiver stalls, the output register holds its result and the
// queue (QueueDepth entries) keeps absorbing bytes; in_ready_o is low while
// the queue holds QueueDepth entries, also in a cycle in which the back drains.
// Reset clears the prefix flags, the pause counter, the queue and the output
// valid; no result is pending after reset.
module ps2_set2_to_hid_usage_decoder_top #(
  parameter int unsigned QueueDepth = ps2hid_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] usage_o,
  output logic       pressed_o
);

  logic             push_valid, push_ready;
  ps2hid_pkg::cmd_t push_cmd;
  logic             pop_valid, pop_ready;
  ps2hid_pkg::cmd_t pop_cmd;

  ps2hid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .scan_byte_i  (scan_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  ps2hid_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ps2hid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .usage_o     (usage_o),
    .pressed_o   (pressed_o)
  );

endmodule

### hdl/ps2hid_front.sv
// Front part: accepts scan bytes, tracks prefix flags and the pause skip count.
// Depends on ps2hid_pkg.
module ps2hid_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        scan_byte_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ps2hid_pkg::cmd_t  push_cmd_o
);

  logic       ext_q, ext_d;
  logic       rel_q, rel_d;
  logic [2:0] pause_cnt_q, pause_cnt_d;
  logic       accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    ext_d            = ext_q;
    rel_d            = rel_q;
    pause_cnt_d      = pause_cnt_q;
    push_cmd_o.kind  = ps2hid_pkg::KindNone;
    push_cmd_o.ext   = ext_q;
    push_cmd_o.rel   = rel_q;
    push_cmd_o.code  = scan_byte_i;
    if (pause_cnt_q != 3'd0) begin
      pause_cnt_d = pause_cnt_q - 3'd1;
    end else if (scan_byte_i == ps2hid_pkg::PfxPause) begin
      ext_d       = 1'b0;
      rel_d       = 1'b0;
      pause_cnt_d = ps2hid_pkg::PauseTail;
    end else if (scan_byte_i == ps2hid_pkg::PfxExt) begin
      ext_d = 1'b1;
    end else if (scan_byte_i == ps2hid_pkg::PfxRel) begin
      rel_d = 1'b1;
    end else begin
      ext_d = 1'b0;
      rel_d = 1'b0;
      // drop the synthetic shift of print screen
      if (!(ext_q && scan_byte_i == ps2hid_pkg::FakeShift)) begin
        push_cmd_o.kind = ps2hid_pkg::KindLookup;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q       <= 1'b0;
      rel_q       <= 1'b0;
      pause_cnt_q <= 3'd0;
    end else if (accept) begin
      ext_q       <= ext_d;
      rel_q       <= rel_d;
      pause_cnt_q <= pause_cnt_d;
    end
  end

endmodule

### hdl/ps2hid_queue.sv
// Short command queue between the front and the back part.
// Depends on ps2hid_pkg.
module ps2hid_queue #(
  parameter int unsigned Depth = ps2hid_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  ps2hid_pkg::cmd_t  push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ps2hid_pkg::cmd_t  pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ps2hid_pkg::cmd_t slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### hdl/ps2hid_back.sv
// Back part: table lookup of queued commands into the registered result.
// Depends on ps2hid_pkg.
module ps2hid_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  ps2hid_pkg::cmd_t  pop_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [7:0]        usage_o,
  output logic              pressed_o
);

  logic                out_valid_q, out_valid_d;
  ps2hid_pkg::status_e status_q, status_d;
  logic [7:0]          usage_q, usage_d;
  logic                pressed_q, pressed_d;
  logic [7:0]          lut_usage;
  logic                load;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign load        = pop_valid_i && pop_ready_o;
  assign lut_usage   = ps2hid_pkg::usage_lookup(pop_cmd_i.code, pop_cmd_i.ext);

  always_comb begin
    status_d  = ps2hid_pkg::StNone;
    usage_d   = 8'h00;
    pressed_d = 1'b0;
    if (pop_cmd_i.kind == ps2hid_pkg::KindLookup) begin
      if (lut_usage == 8'h00) begin
        status_d = ps2hid_pkg::StUnsup;
      end else begin
        status_d  = ps2hid_pkg::StKey;
        usage_d   = lut_usage;
        pressed_d = !pop_cmd_i.rel;
      end
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status_d;
      usage_q   <= usage_d;
      pressed_q <= pressed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign usage_o     = usage_q;
  assign pressed_o   = pressed_q;

endmodule

### hdl/ps2hid_checker.sv
// Port-level assertions for the decoder, bound to the top level.
// Depends on ps2_set2_to_hid_usage_decoder_top_assert.svh and ps2hid_pkg.
`include "ps2_set2_to_hid_usage_decoder_top_assert.svh"

module ps2hid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] usage_o,
  input logic       pressed_o
);

  logic        in_fire;
  logic        out_stall;
  logic [10:0] out_data;
  logic        status_ok;
  logic        zero_ok;
  logic        usage_ok;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_data  = {status_o, usage_o, pressed_o};
  assign status_ok = status_o == ps2hid_pkg::StNone || status_o == ps2hid_pkg::StKey ||
                     status_o == ps2hid_pkg::StUnsup;
  assign zero_ok   = status_o == ps2hid_pkg::StKey || (usage_o == 8'h00 && !pressed_o);
  assign usage_ok  = status_o != ps2hid_pkg::StKey || usage_o != 8'h00;

  // Stalled result transaction holds valid and payload.
  `PS2HID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
                      out_valid_o && $stable(out_data), "stalled result changed")

  `PS2HID_ASSERT(a_status_code, clk_i, rst_ni, !out_valid_o || status_ok, "bad status code")

  `PS2HID_ASSERT(a_no_key_zero, clk_i, rst_ni, !out_valid_o || zero_ok, "fields not zero")

  `PS2HID_ASSERT(a_key_usage, clk_i, rst_ni, !out_valid_o || usage_ok, "key with zero usage")

  // Pass through the queue and the output register: the result channel is valid after the accept.
  `PS2HID_ASSERT_NEXT(a_accept_result, clk_i, rst_ni, in_fire, ##1 out_valid_o,
                      "accepted byte gave no result")

endmodule

bind ps2_set2_to_hid_usage_decoder_top ps2hid_checker u_ps2hid_checker (.*);

### sim/tb.sv
// Self-checking testbench for ps2_set2_to_hid_usage_decoder_top.
// Predicts each HID result from the scan bytes it accepts and checks results in order.
// Depends on ps2hid_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxReports = 10;
  localparam logic [7:0]  PrtScCode  = 8'h7c;

  typedef struct packed {
    ps2hid_pkg::status_e status;
    logic [7:0]          usage;
    logic                pressed;
  } hid_event_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] scan_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [7:0] usage_o;
  logic       pressed_o;

  // decoder state as the keyboard protocol defines it
  logic       ext_seen   = 1'b0;
  logic       rel_seen   = 1'b0;
  logic [2:0] pause_left = 3'd0;

  hid_event_t  expected_events[$];
  int unsigned err_cnt   = 0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  logic        full_rate = 1'b0;

  ps2_set2_to_hid_usage_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .scan_byte_i(scan_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .usage_o    (usage_o),
    .pressed_o  (pressed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Set 2 code (with extended flag in bit 8) to HID usage; zero means no entry.
  function automatic logic [7:0] hid_usage(logic [7:0] code, logic is_ext);
    logic [7:0] u;
    u = 8'h00;
    case ({is_ext, code})
      9'h001: u = 8'h42; 9'h003: u = 8'h3e; 9'h004: u = 8'h3c; 9'h005: u = 8'h3a;
      9'h006: u = 8'h3b; 9'h007: u = 8'h45; 9'h009: u = 8'h43; 9'h00a: u = 8'h41;
      9'h00b: u = 8'h3f; 9'h00c: u = 8'h3d; 9'h00d: u = 8'h2b; 9'h00e: u = 8'h35;
      9'h011: u = 8'he2; 9'h012: u = 8'he1; 9'h014: u = 8'he0; 9'h015: u = 8'h14;
      9'h016: u = 8'h1e; 9'h01a: u = 8'h1d; 9'h01b: u = 8'h16; 9'h01c: u = 8'h04;
      9'h01d: u = 8'h1a; 9'h01e: u = 8'h1f; 9'h021: u = 8'h06; 9'h022: u = 8'h1b;
      9'h023: u = 8'h07; 9'h024: u = 8'h08; 9'h025: u = 8'h21; 9'h026: u = 8'h20;
      9'h029: u = 8'h2c; 9'h02a: u = 8'h19; 9'h02b: u = 8'h09; 9'h02c: u = 8'h17;
      9'h02d: u = 8'h15; 9'h02e: u = 8'h22; 9'h031: u = 8'h11; 9'h032: u = 8'h05;
      9'h033: u = 8'h0b; 9'h034: u = 8'h0a; 9'h035: u = 8'h1c; 9'h036: u = 8'h23;
      9'h03a: u = 8'h10; 9'h03b: u = 8'h0d; 9'h03c: u = 8'h18; 9'h03d: u = 8'h24;
      9'h03e: u = 8'h25; 9'h041: u = 8'h36; 9'h042: u = 8'h0e; 9'h043: u = 8'h0c;
      9'h044: u = 8'h12; 9'h045: u = 8'h27; 9'h046: u = 8'h26; 9'h049: u = 8'h37;
      9'h04a: u = 8'h38; 9'h04b: u = 8'h0f; 9'h04c: u = 8'h33; 9'h04d: u = 8'h13;
      9'h04e: u = 8'h2d; 9'h052: u = 8'h34; 9'h054: u = 8'h2f; 9'h055: u = 8'h2e;
      9'h058: u = 8'h39; 9'h059: u = 8'he5; 9'h05a: u = 8'h28; 9'h05b: u = 8'h30;
      9'h05d: u = 8'h31; 9'h061: u = 8'h64; 9'h066: u = 8'h2a; 9'h069: u = 8'h59;
      9'h06b: u = 8'h5c; 9'h06c: u = 8'h5f; 9'h070: u = 8'h62; 9'h071: u = 8'h63;
      9'h072: u = 8'h5a; 9'h073: u = 8'h5d; 9'h074: u = 8'h5e; 9'h075: u = 8'h60;
      9'h076: u = 8'h29; 9'h077: u = 8'h53; 9'h078: u = 8'h44; 9'h079: u = 8'h57;
      9'h07a: u = 8'h5b; 9'h07b: u = 8'h56; 9'h07c: u = 8'h55; 9'h07d: u = 8'h61;
      9'h07e: u = 8'h47; 9'h083: u = 8'h40;
      9'h111: u = 8'he6; 9'h114: u = 8'he4; 9'h11f: u = 8'he3; 9'h127: u = 8'he7;
      9'h12f: u = 8'h65; 9'h14a: u = 8'h54; 9'h15a: u = 8'h58; 9'h169: u = 8'h4d;
      9'h16b: u = 8'h50; 9'h16c: u = 8'h4a; 9'h170: u = 8'h49; 9'h171: u = 8'h4c;
      9'h172: u = 8'h51; 9'h174: u = 8'h4f; 9'h175: u = 8'h52; 9'h17a: u = 8'h4e;
      9'h17c: u = 8'h46; 9'h17d: u = 8'h4b;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  // Advance the prefix flags and pause counter by one byte; return its event.
  function automatic hid_event_t decode_scan_byte(logic [7:0] b);
    hid_event_t ev;
    logic       is_ext;
    logic       is_rel;
    logic [7:0] u;
    ev = '{ps2hid_pkg::StNone, 8'h00, 1'b0};
    if (pause_left != 3'd0) begin
      pause_left = pause_left - 3'd1;
    end else if (b == ps2hid_pkg::PfxPause) begin
      ext_seen   = 1'b0;
      rel_seen   = 1'b0;
      pause_left = ps2hid_pkg::PauseTail;
    end else if (b == ps2hid_pkg::PfxExt) begin
      ext_seen = 1'b1;
    end else if (b == ps2hid_pkg::PfxRel) begin
      rel_seen = 1'b1;
    end else begin
      is_ext   = ext_seen;
      is_rel   = rel_seen;
      ext_seen = 1'b0;
      rel_seen = 1'b0;
      if (!(is_ext && b == ps2hid_pkg::FakeShift)) begin
        u = hid_usage(b, is_ext);
        if (u == 8'h00) begin
          ev.status = ps2hid_pkg::StUnsup;
        end else begin
          ev = '{ps2hid_pkg::StKey, u, !is_rel};
        end
      end
    end
    return ev;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("ERROR: %s", msg);
  endtask

  // Predict every accepted byte.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_events.push_back(decode_scan_byte(scan_byte_i));
    end
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    hid_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d usage %02h pressed %0b",
                             status_o, usage_o, pressed_o));
      end else begin
        want = expected_events.pop_front();
        if (status_o !== want.status || usage_o !== want.usage ||
            pressed_o !== want.pressed) begin
          flag_error($sformatf(
            "mismatch: expected status %0d usage %02h pressed %0b, got %0d %02h %0b",
            want.status, want.usage, want.pressed, status_o, usage_o, pressed_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= full_rate || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold valid and the byte until the transaction completes; idle now and then.
  task automatic send_byte(input logic [7:0] b);
    while (!full_rate && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Random code, steered toward one the table knows.
  function automatic logic [7:0] pick_code(logic is_ext);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    for (int i = 0; i < 20 && hid_usage(c, is_ext) == 8'h00; i++) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // One well-formed keyboard sequence with random content.
  task automatic send_key_sequence();
    logic is_ext;
    is_ext = $urandom_range(0, 2) == 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (is_ext) send_byte(ps2hid_pkg::PfxExt);
        send_byte(pick_code(is_ext));
      end
      4, 5, 6: begin
        if (is_ext) send_byte(ps2hid_pkg::PfxExt);
        send_byte(ps2hid_pkg::PfxRel);
        send_byte(pick_code(is_ext));
      end
      7: begin
        send_byte(ps2hid_pkg::PfxPause);
        repeat (ps2hid_pkg::PauseTail) send_byte(8'($urandom_range(0, 255)));
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::FakeShift);
          send_byte(ps2hid_pkg::PfxExt); send_byte(PrtScCode);
        end else begin
          send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::PfxRel);
          send_byte(PrtScCode);
          send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::PfxRel);
          send_byte(ps2hid_pkg::FakeShift);
        end
      end
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic test_directed();
    // field extremes, plain make, extended make
    send_byte(8'h00); send_byte(8'hff); send_byte(8'h1c);
    send_byte(ps2hid_pkg::PfxExt); send_byte(8'h75);
    // repeated prefixes keep their flags: extended break
    send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::PfxRel);
    send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::PfxRel);
    send_byte(8'h6b);
    // synthetic shift, then a code without an entry
    send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::FakeShift); send_byte(8'h02);
    // pause clears a pending prefix and swallows prefixes in its tail
    send_byte(ps2hid_pkg::PfxExt); send_byte(ps2hid_pkg::PfxPause);
    send_byte(8'h14); send_byte(8'h77); send_byte(ps2hid_pkg::PfxPause);
    send_byte(ps2hid_pkg::PfxRel);
    send_byte(8'h14); send_byte(ps2hid_pkg::PfxRel); send_byte(8'h77);
    send_byte(8'h83);
  endtask

  task automatic test_full_rate(input int unsigned target);
    full_rate <= 1'b1;
    while (sent_cnt < target) send_key_sequence();
    full_rate <= 1'b0;
  endtask

  task automatic test_key_sequences(input int unsigned target);
    while (sent_cnt < target) send_key_sequence();
  endtask

  // Raw bytes with a heavy share of prefixes.
  task automatic test_noise(input int unsigned target);
    while (sent_cnt < target) begin
      case ($urandom_range(0, 9))
        0, 1:    send_byte(ps2hid_pkg::PfxExt);
        2, 3:    send_byte(ps2hid_pkg::PfxRel);
        4:       send_byte(ps2hid_pkg::PfxPause);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_rate(sent_cnt + 120);
    test_key_sequences(sent_cnt + 460);
    test_noise(sent_cnt + 250);

    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_events.size() != 0) flag_error("results missing at end of run");

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/ps2hid_pkg.sv
hdl/ps2hid_front.sv
hdl/ps2hid_queue.sv
hdl/ps2hid_back.sv
hdl/ps2_set2_to_hid_usage_decoder_top.sv
hdl/ps2hid_checker.sv
sim/tb.sv
